// ===== src/spring_force_push_pull_assert.svh =====
// Assertion macros shared by the spring force modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef SPRING_FORCE_PUSH_PULL_ASSERT_SVH
`define SPRING_FORCE_PUSH_PULL_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SPF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define SPF_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`else

`define SPF_ASSERT(lbl, prop)

`define SPF_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ===== src/spf_pkg.sv =====
// ----------------------------------------------------------------------------
// spf_pkg
// Widths, payload types and register codes of the spring force engine.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int CW  = 32;
    localparam int FB  = 16;
    localparam int DW  = CW + 1;
    localparam int SW  = 2 * DW;
    localparam int SQW = SW + 2;
    localparam int LW  = DW;
    localparam int MW  = CW + DW;
    localparam int NW  = MW + DW;
    localparam int QW  = CW + 1;
    localparam int DVW = LW + FB;
    localparam int KW  = 32;
    localparam int RW  = 31;
    localparam int CFG_DW = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FAW = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        REG_SPRING_CONSTANT = 2'd0,
        REG_REST_LENGTH     = 2'd1,
        REG_PUSH_ENABLE     = 2'd2,
        REG_PULL_ENABLE     = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [CW-1:0] pos_x;
        logic signed [CW-1:0] pos_y;
        logic signed [CW-1:0] pos_z;
        logic signed [CW-1:0] other_x;
        logic signed [CW-1:0] other_y;
        logic signed [CW-1:0] other_z;
    } in_item_t;

    typedef struct packed {
        logic signed [CW-1:0] force_x;
        logic signed [CW-1:0] force_y;
        logic signed [CW-1:0] force_z;
        logic                 applied;
    } out_item_t;

    typedef struct packed {
        logic [KW-1:0] spring_constant;
        logic [RW-1:0] rest_length;
        logic          push_enable;
        logic          pull_enable;
    } cfg_t;

    typedef logic signed [DW-1:0] diff_t;

    typedef struct packed {
        diff_t [2:0]   d;
        logic [LW-1:0] len;
        logic [LW-1:0] len_delta;
        logic          stretched;
        logic          acts;
        logic          zero_len;
    } task_t;

endpackage

// ===== src/spf_front.sv =====
// ----------------------------------------------------------------------------
// spf_front
// Forms the difference vector and its length, and classifies the spring mode.
// ----------------------------------------------------------------------------
module spf_front
    import spf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  logic     full,
    output logic     push,
    output task_t    task_out
);

    logic adv;

    logic                a_valid_reg;
    diff_t [2:0]         a_d_reg;
    logic                b_valid_reg;
    diff_t [2:0]         b_d_reg;
    logic [2:0][DW-1:0]  b_mag_reg;
    logic                c_valid_reg;
    diff_t [2:0]         c_d_reg;
    logic [2:0][SW-1:0]  c_sq_reg;

    logic                s_valid_reg [0:LW];
    diff_t [2:0]         s_d_reg     [0:LW];
    logic [SQW-1:0]      s_x_reg     [0:LW];
    logic [SQW-1:0]      s_res_reg   [0:LW];
    logic [SQW-1:0]      s_x_next    [0:LW-1];
    logic [SQW-1:0]      s_res_next  [0:LW-1];

    logic                cls_valid_reg;
    task_t               cls_reg;
    task_t               cls_next;

    logic signed [CW-1:0] pos   [0:2];
    logic signed [CW-1:0] other [0:2];
    diff_t [2:0]          d_next;
    logic [2:0][DW-1:0]   mag_next;
    logic [2:0][SW-1:0]   sq_next;
    logic [SW-1:0]        sum_next;
    logic [LW-1:0]        root;
    logic [LW-1:0]        rest;
    logic                 acts_next;

    assign adv      = !cls_valid_reg || !full;
    assign in_stall = !adv;
    assign push     = cls_valid_reg && !full;
    assign task_out = cls_reg;

    assign pos[0]   = in_data.pos_x;
    assign pos[1]   = in_data.pos_y;
    assign pos[2]   = in_data.pos_z;
    assign other[0] = in_data.other_x;
    assign other[1] = in_data.other_y;
    assign other[2] = in_data.other_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_next[i]   = $signed({pos[i][CW-1], pos[i]}) - $signed({other[i][CW-1], other[i]});
            mag_next[i] = a_d_reg[i][DW-1] ? (~a_d_reg[i] + 1'b1) : a_d_reg[i];
            sq_next[i]  = SW'(b_mag_reg[i]) * SW'(b_mag_reg[i]);
        end
        sum_next = c_sq_reg[0] + c_sq_reg[1] + c_sq_reg[2];
    end

    always_comb
    begin
        logic [SQW-1:0] bitv;
        logic [SQW-1:0] trial;
        for (int j = 0; j < LW; j++)
        begin
            bitv  = SQW'(1) << (2 * (LW - 1 - j));
            trial = s_res_reg[j] + bitv;
            if (s_x_reg[j] >= trial)
            begin
                s_x_next[j]   = s_x_reg[j] - trial;
                s_res_next[j] = (s_res_reg[j] >> 1) + bitv;
            end
            else
            begin
                s_x_next[j]   = s_x_reg[j];
                s_res_next[j] = s_res_reg[j] >> 1;
            end
        end
    end

    assign root = s_res_reg[LW][LW-1:0];
    assign rest = LW'(cfg.rest_length);

    always_comb
    begin
        acts_next = 1'b1;
        if (cfg.push_enable != cfg.pull_enable)
        begin
            if (cfg.push_enable && root >= rest)
            begin
                acts_next = 1'b0;
            end
            if (cfg.pull_enable && root <= rest)
            begin
                acts_next = 1'b0;
            end
        end
        cls_next.d         = s_d_reg[LW];
        cls_next.len       = root;
        cls_next.stretched = root > rest;
        cls_next.len_delta = (root > rest) ? (root - rest) : (rest - root);
        cls_next.acts      = acts_next;
        cls_next.zero_len  = (root == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            cls_valid_reg <= 1'b0;
            for (int j = 0; j <= LW; j++)
            begin
                s_valid_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_valid_reg    <= in_valid;
            b_valid_reg    <= a_valid_reg;
            c_valid_reg    <= b_valid_reg;
            s_valid_reg[0] <= c_valid_reg;
            for (int j = 0; j < LW; j++)
            begin
                s_valid_reg[j+1] <= s_valid_reg[j];
            end
            cls_valid_reg  <= s_valid_reg[LW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_d_reg      <= d_next;
            b_d_reg      <= a_d_reg;
            b_mag_reg    <= mag_next;
            c_d_reg      <= b_d_reg;
            c_sq_reg     <= sq_next;
            s_d_reg[0]   <= c_d_reg;
            s_x_reg[0]   <= SQW'(sum_next);
            s_res_reg[0] <= '0;
            for (int j = 0; j < LW; j++)
            begin
                s_d_reg[j+1]   <= s_d_reg[j];
                s_x_reg[j+1]   <= s_x_next[j];
                s_res_reg[j+1] <= s_res_next[j];
            end
            cls_reg <= cls_next;
        end
    end

endmodule

// ===== src/spf_fifo.sv =====
// ----------------------------------------------------------------------------
// spf_fifo
// Short queue of classified springs between the front and the back.
// ----------------------------------------------------------------------------
`include "spring_force_push_pull_assert.svh"

module spf_fifo
    import spf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  task_t wdata,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output task_t rdata
);

    localparam logic [FAW:0] DEPTH_C = (FAW + 1)'(FIFO_DEPTH);

    task_t          mem [0:FIFO_DEPTH-1];
    logic [FAW-1:0] wr_ptr_reg;
    logic [FAW-1:0] rd_ptr_reg;
    logic [FAW:0]   count_reg;

    assign full  = (count_reg == DEPTH_C);
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    `SPF_ASSERT(fifo_no_overflow_a, push |-> count_reg != DEPTH_C)
    `SPF_ASSERT(fifo_no_underflow_a, pop |-> count_reg != '0)
    `SPF_ASSERT_NEXT(fifo_count_up_a, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== src/spf_back.sv =====
// ----------------------------------------------------------------------------
// spf_back
// Scales the difference vector by k*|L-R|/L, divides and saturates.
// ----------------------------------------------------------------------------
`include "spring_force_push_pull_assert.svh"

module spf_back
    import spf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [KW-1:0] spring_constant,
    input  logic          empty,
    input  task_t         head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output out_item_t     out_data
);

    localparam int OW = NW - FB - QW;

    logic adv;

    logic                 v0_reg;
    logic [MW-1:0]        m0_reg;
    logic [2:0][DW-1:0]   mag0_reg;
    logic [2:0]           neg0_reg;
    logic [LW-1:0]        len0_reg;
    logic                 kill0_reg;
    logic                 app0_reg;

    logic                 v1_reg;
    logic [2:0][CW+DW-1:0] plo1_reg;
    logic [2:0][2*DW-1:0] phi1_reg;
    logic [2:0]           neg1_reg;
    logic [LW-1:0]        len1_reg;
    logic                 kill1_reg;
    logic                 app1_reg;

    logic                 v2_reg;
    logic [2:0][NW-1:0]   num2_reg;
    logic [2:0]           neg2_reg;
    logic [LW-1:0]        len2_reg;
    logic                 kill2_reg;
    logic                 app2_reg;

    logic                 dv_valid_reg [0:QW];
    logic [2:0][DVW-1:0]  dv_rem_reg   [0:QW];
    logic [2:0][QW-1:0]   dv_low_reg   [0:QW];
    logic [2:0][QW-1:0]   dv_q_reg     [0:QW];
    logic [2:0]           dv_ovf_reg   [0:QW];
    logic [2:0]           dv_neg_reg   [0:QW];
    logic [DVW-1:0]       dv_div_reg   [0:QW];
    logic                 dv_kill_reg  [0:QW];
    logic                 dv_app_reg   [0:QW];

    logic [2:0][DVW-1:0]  rem_next [0:QW-1];
    logic [2:0]           qbit_next [0:QW-1];

    logic                 out_valid_reg;
    out_item_t            out_reg;
    out_item_t            out_next;

    logic [2:0][DW-1:0]   mag_next;
    logic [2:0]           neg_next;
    logic [2:0][CW-1:0]   force_next;
    logic [2:0]           ovf_next;

    assign adv       = !out_valid_reg || !out_stall;
    assign pop       = adv && !empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = head.d[i][DW-1] ? (~head.d[i] + 1'b1) : head.d[i];
            neg_next[i] = ((head.d[i] > 0) == head.stretched);
            ovf_next[i] = (num2_reg[i][NW-1:FB+QW] >= OW'(len2_reg));
        end
    end

    always_comb
    begin
        logic [DVW:0] t;
        for (int j = 0; j < QW; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t = {dv_rem_reg[j][i], dv_low_reg[j][i][QW-1]};
                if (t >= {1'b0, dv_div_reg[j]})
                begin
                    t               = t - {1'b0, dv_div_reg[j]};
                    qbit_next[j][i] = 1'b1;
                end
                else
                begin
                    qbit_next[j][i] = 1'b0;
                end
                rem_next[j][i] = t[DVW-1:0];
            end
        end
    end

    always_comb
    begin
        logic [QW-1:0] lim;
        logic [QW-1:0] qv;
        logic [QW-1:0] neg_q;
        for (int i = 0; i < 3; i++)
        begin
            lim = (QW'(1) << (CW - 1)) - QW'(!dv_neg_reg[QW][i]);
            qv  = dv_q_reg[QW][i];
            if (dv_ovf_reg[QW][i] || qv > lim)
            begin
                qv = lim;
            end
            neg_q = ~qv + 1'b1;
            if (dv_kill_reg[QW])
            begin
                force_next[i] = '0;
            end
            else
            begin
                force_next[i] = dv_neg_reg[QW][i] ? neg_q[CW-1:0] : qv[CW-1:0];
            end
        end
        out_next.force_x = force_next[0];
        out_next.force_y = force_next[1];
        out_next.force_z = force_next[2];
        out_next.applied = dv_app_reg[QW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j <= QW; j++)
            begin
                dv_valid_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v0_reg          <= pop;
            v1_reg          <= v0_reg;
            v2_reg          <= v1_reg;
            dv_valid_reg[0] <= v2_reg;
            for (int j = 0; j < QW; j++)
            begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
            out_valid_reg   <= dv_valid_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m0_reg    <= MW'(spring_constant) * MW'(head.len_delta);
            mag0_reg  <= mag_next;
            neg0_reg  <= neg_next;
            len0_reg  <= head.len;
            kill0_reg <= !head.acts || head.zero_len;
            app0_reg  <= head.acts;

            for (int i = 0; i < 3; i++)
            begin
                plo1_reg[i] <= (CW+DW)'(m0_reg[CW-1:0]) * (CW+DW)'(mag0_reg[i]);
                phi1_reg[i] <= (2*DW)'(m0_reg[MW-1:CW]) * (2*DW)'(mag0_reg[i]);
                num2_reg[i] <= (NW'(phi1_reg[i]) << CW) + NW'(plo1_reg[i]);
            end
            neg1_reg  <= neg0_reg;
            len1_reg  <= len0_reg;
            kill1_reg <= kill0_reg;
            app1_reg  <= app0_reg;
            neg2_reg  <= neg1_reg;
            len2_reg  <= len1_reg;
            kill2_reg <= kill1_reg;
            app2_reg  <= app1_reg;

            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= num2_reg[i][QW+DVW-1:QW];
                dv_low_reg[0][i] <= num2_reg[i][QW-1:0];
            end
            dv_q_reg[0]    <= '0;
            dv_ovf_reg[0]  <= ovf_next;
            dv_neg_reg[0]  <= neg2_reg;
            dv_div_reg[0]  <= {len2_reg, {FB{1'b0}}};
            dv_kill_reg[0] <= kill2_reg;
            dv_app_reg[0]  <= app2_reg;

            for (int j = 0; j < QW; j++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dv_rem_reg[j+1][i] <= rem_next[j][i];
                    dv_low_reg[j+1][i] <= {dv_low_reg[j][i][QW-2:0], 1'b0};
                    dv_q_reg[j+1][i]   <= {dv_q_reg[j][i][QW-2:0], qbit_next[j][i]};
                end
                dv_ovf_reg[j+1]  <= dv_ovf_reg[j];
                dv_neg_reg[j+1]  <= dv_neg_reg[j];
                dv_div_reg[j+1]  <= dv_div_reg[j];
                dv_kill_reg[j+1] <= dv_kill_reg[j];
                dv_app_reg[j+1]  <= dv_app_reg[j];
            end

            out_reg <= out_next;
        end
    end

    `SPF_ASSERT(back_suppressed_zero_a, (out_valid_reg && !out_reg.applied) |-> (out_reg.force_x == 0 && out_reg.force_y == 0 && out_reg.force_z == 0))
    `SPF_ASSERT_NEXT(back_hold_a, out_valid_reg && out_stall, out_valid_reg && $stable(out_reg))
    `SPF_ASSERT(back_pop_moves_a, pop |-> adv && !empty)

endmodule

// ===== src/spring_force_push_pull.sv =====
// ----------------------------------------------------------------------------
// spring_force_push_pull
// Hooke's law spring force with push and pull modes, one spring per cycle unless stalled.
// ----------------------------------------------------------------------------
// The input channel carries a particle position and the position of the
// spring's other end; the output channel carries the force on the particle
// and a flag that tells whether the spring acted. Each channel uses valid
// and stall, and a transfer happens at a clock edge with valid high and
// stall low. Registers are written through cfg_we, cfg_index and cfg_wdata;
// the user must write them only while no spring is in flight; the block
// itself does not enforce this. The length comes from a one-bit-per-stage
// square root pipeline; the result then passes the queue, the scaling and
// the one-bit-per-stage divider. One spring is taken every cycle while
// no stall holds the flow.
// Reset empties both pipelines and the queue and loads the register
// defaults. When the receiver stalls, the back part holds its result and the
// front keeps working until the four-entry queue fills, then stalls input.
module spring_force_push_pull
    import spf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data,
    input  logic              cfg_we,
    input  reg_index_t        cfg_index,
    input  logic [CFG_DW-1:0] cfg_wdata
);

    cfg_t  cfg_reg;
    logic  full;
    logic  empty;
    logic  push;
    logic  pop;
    task_t front_task;
    task_t head_task;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spring_constant <= KW'(65536);
            cfg_reg.rest_length     <= RW'(65536);
            cfg_reg.push_enable     <= 1'b1;
            cfg_reg.pull_enable     <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPRING_CONSTANT: cfg_reg.spring_constant <= cfg_wdata[KW-1:0];
                REG_REST_LENGTH:     cfg_reg.rest_length     <= cfg_wdata[RW-1:0];
                REG_PUSH_ENABLE:     cfg_reg.push_enable     <= cfg_wdata[0];
                REG_PULL_ENABLE:     cfg_reg.pull_enable     <= cfg_wdata[0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    spf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .full     (full),
        .push     (push),
        .task_out (front_task)
    );

    spf_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_task),
        .full  (full),
        .pop   (pop),
        .empty (empty),
        .rdata (head_task)
    );

    spf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .spring_constant (cfg_reg.spring_constant),
        .empty           (empty),
        .head            (head_task),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data)
    );

endmodule
